// ===== src/mmts_pkg.sv =====
package mmts_pkg;

	// default sizes
	localparam int DEF_NUM_TYPES     = 64;
	localparam int DEF_NUM_LEVELS    = 4;
	localparam int DEF_NUM_DIVISIONS = 8;

	// register map and reset value
	localparam int          REG_BASE_INTERVAL = 0;
	localparam logic [15:0] BASE_RESET        = 16'd10;

	// item kinds and result status codes
	localparam logic       ACT_RECORD    = 1'b0;
	localparam logic       ACT_READ      = 1'b1;
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_BAD_TYPE  = 2'd1;
	localparam logic [1:0] STS_BAD_LEVEL = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LIVE_RD,
		ST_REC_WR,
		ST_L0_RD,
		ST_L0_WR,
		ST_LVL_CHK,
		ST_SUM_RD,
		ST_SUM_WAIT,
		ST_LVL_WR,
		ST_RING_RD,
		ST_RING_WAIT,
		ST_DONE
	} state_t;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic        load;
		logic        live_rd;
		logic        rec_wr;
		logic        l0_wr;
		logic        lvl_wr;
		logic        clr_wr;
		logic        bkt_rd;
		logic        sum_clr;
		logic        adv;
		logic        res_load;
		logic        use_item;
		logic [2:0]  rd_lvl;
		logic [2:0]  wr_lvl;
		logic [6:0]  typ;
		logic [5:0]  div;
		logic [15:0] clr_addr;
	} cmd_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic it_bad;
		logic it_read;
		logic roll0;
		logic roll_lvl;
		logic out_free;
	} sts_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

// ===== src/mmts_ctrl.sv =====
module mmts_ctrl #(
	parameter int NUM_TYPES     = mmts_pkg::DEF_NUM_TYPES,
	parameter int NUM_LEVELS    = mmts_pkg::DEF_NUM_LEVELS,
	parameter int NUM_DIVISIONS = mmts_pkg::DEF_NUM_DIVISIONS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  mmts_pkg::sts_t  sts,
	output mmts_pkg::cmd_t  cmd
);

	localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int DW = $clog2(NUM_DIVISIONS);
	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int AW = LW + TW + DW;
	localparam logic [TW:0] NT_W = (TW + 1)'(NUM_TYPES);

	mmts_pkg::state_t state_q, state_d;
	logic [TW-1:0] t_q;
	logic [DW-1:0] d_q;
	logic [LW-1:0] lvl_q;
	logic [AW-1:0] clr_q;
	logic t_last, d_last, lvl_last, accept;

	assign t_last   = (t_q == TW'(NUM_TYPES - 1));
	assign d_last   = (d_q == DW'(NUM_DIVISIONS - 1));
	assign lvl_last = (lvl_q == LW'(NUM_LEVELS - 1));
	assign s_tready = (state_q == mmts_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mmts_pkg::ST_CLEAR:     if (&clr_q) state_d = mmts_pkg::ST_IDLE;
			mmts_pkg::ST_IDLE:      if (s_tvalid) state_d = mmts_pkg::ST_LIVE_RD;
			mmts_pkg::ST_LIVE_RD: begin
				if (sts.it_bad) state_d = mmts_pkg::ST_DONE;
				else if (sts.it_read) state_d = mmts_pkg::ST_RING_RD;
				else state_d = mmts_pkg::ST_REC_WR;
			end
			mmts_pkg::ST_REC_WR:
				state_d = sts.roll0 ? mmts_pkg::ST_L0_RD : mmts_pkg::ST_DONE;
			mmts_pkg::ST_L0_RD:     state_d = mmts_pkg::ST_L0_WR;
			mmts_pkg::ST_L0_WR: begin
				if (!t_last) state_d = mmts_pkg::ST_L0_RD;
				else if (NUM_LEVELS > 1) state_d = mmts_pkg::ST_LVL_CHK;
				else state_d = mmts_pkg::ST_DONE;
			end
			mmts_pkg::ST_LVL_CHK:
				state_d = sts.roll_lvl ? mmts_pkg::ST_SUM_RD : mmts_pkg::ST_DONE;
			mmts_pkg::ST_SUM_RD:    if (d_last) state_d = mmts_pkg::ST_SUM_WAIT;
			mmts_pkg::ST_SUM_WAIT:  state_d = mmts_pkg::ST_LVL_WR;
			mmts_pkg::ST_LVL_WR: begin
				if (!t_last) state_d = mmts_pkg::ST_SUM_RD;
				else if (lvl_last) state_d = mmts_pkg::ST_DONE;
				else state_d = mmts_pkg::ST_LVL_CHK;
			end
			mmts_pkg::ST_RING_RD:   if (d_last) state_d = mmts_pkg::ST_RING_WAIT;
			mmts_pkg::ST_RING_WAIT: state_d = mmts_pkg::ST_DONE;
			mmts_pkg::ST_DONE:      if (sts.out_free) state_d = mmts_pkg::ST_IDLE;
			default:                state_d = mmts_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		cmd.typ = 7'(t_q);
		cmd.div = 6'(d_q);
		cmd.wr_lvl = 3'(lvl_q);
		cmd.rd_lvl = 3'(lvl_q - 1'b1);
		cmd.clr_addr = 16'(clr_q);
		unique case (state_q)
			mmts_pkg::ST_CLEAR:   cmd.clr_wr = 1'b1;
			mmts_pkg::ST_IDLE:    cmd.load = s_tvalid;
			mmts_pkg::ST_LIVE_RD: begin
				cmd.live_rd = 1'b1;
				cmd.use_item = 1'b1;
			end
			mmts_pkg::ST_REC_WR: begin
				cmd.rec_wr = 1'b1;
				cmd.use_item = 1'b1;
			end
			mmts_pkg::ST_L0_RD:   cmd.live_rd = 1'b1;
			mmts_pkg::ST_L0_WR: begin
				cmd.l0_wr = 1'b1;
				cmd.wr_lvl = 3'd0;
				cmd.adv = t_last;
			end
			mmts_pkg::ST_SUM_RD: begin
				cmd.bkt_rd = 1'b1;
				cmd.sum_clr = (d_q == '0);
			end
			mmts_pkg::ST_LVL_WR: begin
				cmd.lvl_wr = 1'b1;
				cmd.adv = t_last;
			end
			mmts_pkg::ST_RING_RD: begin
				cmd.bkt_rd = 1'b1;
				cmd.use_item = 1'b1;
				cmd.sum_clr = (d_q == '0);
			end
			mmts_pkg::ST_DONE:    cmd.res_load = sts.out_free;
			default: ;
		endcase
	end

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmts_pkg::ST_CLEAR;
			t_q <= '0;
			d_q <= '0;
			lvl_q <= '0;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mmts_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			unique case (state_q)
				mmts_pkg::ST_IDLE: begin
					t_q <= '0;
					d_q <= '0;
				end
				mmts_pkg::ST_L0_WR: begin
					if (t_last) begin
						t_q <= '0;
						lvl_q <= LW'(1);
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				mmts_pkg::ST_LVL_CHK: begin
					t_q <= '0;
					d_q <= '0;
				end
				mmts_pkg::ST_SUM_RD, mmts_pkg::ST_RING_RD:
					d_q <= d_last ? '0 : d_q + 1'b1;
				mmts_pkg::ST_LVL_WR: begin
					if (t_last) begin
						t_q <= '0;
						if (!lvl_last) lvl_q <= lvl_q + 1'b1;
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> sts.out_free) else $error("result loaded over a pending result");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == mmts_pkg::ST_LIVE_RD) else $error("accepted item not started");
	a_type_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, t_q} < NT_W) else $error("type counter out of range");
	a_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_wr && (cmd.l0_wr || cmd.lvl_wr))) else $error("bucket write clash");

endmodule

// ===== src/mmts_dp.sv =====
module mmts_dp #(
	parameter int NUM_TYPES     = mmts_pkg::DEF_NUM_TYPES,
	parameter int NUM_LEVELS    = mmts_pkg::DEF_NUM_LEVELS,
	parameter int NUM_DIVISIONS = mmts_pkg::DEF_NUM_DIVISIONS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mmts_pkg::cmd_t  cmd,
	output mmts_pkg::sts_t  sts,
	input  logic [79:0]     s_tdata,
	input  logic [0:0]      s_tuser,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [95:0]     m_tdata,
	output logic [1:0]      m_tuser,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int DW = $clog2(NUM_DIVISIONS);
	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int AW = LW + TW + DW;
	localparam int BDEPTH = 1 << AW;
	localparam logic [7:0] NT8 = 8'(NUM_TYPES);
	localparam logic [3:0] NL4 = 4'(NUM_LEVELS);

	// configuration register
	logic [15:0] base_q;
	logic reg_sel;
	assign reg_sel = (paddr[2:2] == 1'(mmts_pkg::REG_BASE_INTERVAL));
	assign pready = 1'b1;
	assign prdata = reg_sel ? {16'b0, base_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_q <= mmts_pkg::BASE_RESET;
		else if (psel && penable && pwrite && reg_sel) base_q <= pwdata[15:0];
	end

	// captured input transaction
	logic        act_q;
	logic [6:0]  type_q;
	logic [30:0] size_q;
	logic [31:0] now_q;
	logic [2:0]  level_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= s_tuser[0];
			type_q <= s_tdata[6:0];
			size_q <= s_tdata[37:7];
			now_q <= s_tdata[69:38];
			level_q <= s_tdata[72:70];
		end
	end

	logic type_bad, level_bad;
	assign type_bad  = ({1'b0, type_q} >= NT8);
	assign level_bad = (act_q == mmts_pkg::ACT_READ) && ({1'b0, level_q} >= NL4);

	// live accumulators: {largest, count, size} per type
	logic [94:0] live_mem [NUM_TYPES];
	logic [94:0] live_q;
	logic [NUM_TYPES-1:0] live_vld_q, max_vld_q;
	logic live_v_q, max_v_q;
	logic [TW-1:0] live_addr;
	logic [31:0] old_sz, old_cnt, new_sz, new_cnt;
	logic [30:0] old_max, new_max, rec_max_q;

	assign live_addr = cmd.use_item ? type_q[TW-1:0] : cmd.typ[TW-1:0];
	assign old_sz  = live_v_q ? live_q[31:0] : 32'b0;
	assign old_cnt = live_v_q ? live_q[63:32] : 32'b0;
	assign old_max = max_v_q ? live_q[94:64] : 31'b0;
	assign new_sz  = mmts_pkg::sat_add(old_sz, {1'b0, size_q});
	assign new_cnt = mmts_pkg::sat_add(old_cnt, 32'd1);
	assign new_max = (old_max < size_q) ? size_q : old_max;

	always_ff @(posedge clk) begin
		if (cmd.live_rd) live_q <= live_mem[live_addr];
		if (cmd.rec_wr) live_mem[live_addr] <= {new_max, new_cnt, new_sz};
		if (cmd.rec_wr) rec_max_q <= new_max;
	end

	// entry valid bits stand in for clearing the live store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_vld_q <= '0;
			max_vld_q <= '0;
			live_v_q <= 1'b0;
			max_v_q <= 1'b0;
		end else begin
			if (cmd.live_rd) begin
				live_v_q <= live_vld_q[live_addr];
				max_v_q <= max_vld_q[live_addr];
			end
			if (cmd.rec_wr) begin
				live_vld_q[live_addr] <= 1'b1;
				max_vld_q[live_addr] <= 1'b1;
			end else if (cmd.l0_wr) begin
				live_vld_q[live_addr] <= 1'b0;
			end
		end
	end

	// level stamps, ring slots and level interval
	logic [31:0] stamp_q [NUM_LEVELS];
	logic [DW-1:0] slot_q [NUM_LEVELS];
	logic [63:0] interval_q;
	logic [LW-1:0] wl;
	assign wl = cmd.wr_lvl[LW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				stamp_q[i] <= '0;
				slot_q[i] <= '0;
			end
		end else if (cmd.adv) begin
			stamp_q[wl] <= now_q;
			slot_q[wl] <= (slot_q[wl] == DW'(NUM_DIVISIONS - 1)) ? '0 : slot_q[wl] + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.adv) begin
			if (wl == '0) interval_q <= 64'(base_q) * 64'(NUM_DIVISIONS);
			else interval_q <= interval_q * 64'(NUM_DIVISIONS);
		end
	end

	assign sts.roll0 = ({1'b0, stamp_q[0]} + 33'(base_q)) < {1'b0, now_q};
	assign sts.roll_lvl = ({33'b0, stamp_q[wl]} + {1'b0, interval_q}) <= {33'b0, now_q};

	// ring buckets: {count, size} at {level, type, slot}
	logic [63:0] bkt_mem [BDEPTH];
	logic [63:0] bkt_q, bkt_wdata;
	logic [AW-1:0] bkt_waddr, bkt_raddr;
	logic bkt_we, pend_q;
	logic [31:0] acc_cnt_q, acc_sz_q;

	assign bkt_we = cmd.clr_wr || cmd.l0_wr || cmd.lvl_wr;
	assign bkt_waddr = cmd.clr_wr ? cmd.clr_addr[AW-1:0]
		: {wl, cmd.typ[TW-1:0], slot_q[wl]};
	assign bkt_raddr = cmd.use_item
		? {level_q[LW-1:0], type_q[TW-1:0], cmd.div[DW-1:0]}
		: {cmd.rd_lvl[LW-1:0], cmd.typ[TW-1:0], cmd.div[DW-1:0]};

	always_comb begin
		priority if (cmd.lvl_wr) bkt_wdata = {acc_cnt_q, acc_sz_q};
		else if (cmd.l0_wr) bkt_wdata = live_v_q ? live_q[63:0] : 64'b0;
		else bkt_wdata = 64'b0;
	end

	always_ff @(posedge clk) begin
		if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
		if (cmd.bkt_rd) bkt_q <= bkt_mem[bkt_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 1'b0;
		else pend_q <= cmd.bkt_rd;
	end

	// saturating ring sum
	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			acc_cnt_q <= '0;
			acc_sz_q <= '0;
		end else if (pend_q) begin
			acc_cnt_q <= mmts_pkg::sat_add(acc_cnt_q, bkt_q[63:32]);
			acc_sz_q <= mmts_pkg::sat_add(acc_sz_q, bkt_q[31:0]);
		end
	end

	// result register
	logic [1:0]  res_sts_q;
	logic [31:0] res_cnt_q, res_sz_q;
	logic [30:0] res_max_q;
	logic        m_tvalid_q;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_cnt_q <= '0;
			res_sz_q <= '0;
			res_max_q <= '0;
			if (type_bad) begin
				res_sts_q <= mmts_pkg::STS_BAD_TYPE;
			end else if (level_bad) begin
				res_sts_q <= mmts_pkg::STS_BAD_LEVEL;
			end else if (act_q == mmts_pkg::ACT_READ) begin
				res_sts_q <= mmts_pkg::STS_OK;
				res_cnt_q <= acc_cnt_q;
				res_sz_q <= acc_sz_q;
				res_max_q <= old_max;
			end else begin
				res_sts_q <= mmts_pkg::STS_OK;
				res_max_q <= rec_max_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid_q <= 1'b0;
		else if (cmd.res_load) m_tvalid_q <= 1'b1;
		else if (m_tready) m_tvalid_q <= 1'b0;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, res_max_q, res_sz_q, res_cnt_q};
	assign m_tuser  = res_sts_q;

	assign sts.it_bad   = type_bad || level_bad;
	assign sts.it_read  = (act_q == mmts_pkg::ACT_READ);
	assign sts.out_free = !m_tvalid_q || m_tready;

endmodule

// ===== src/multilevel_message_traffic_stats_top.sv =====
// Per-type message traffic statistics kept at several time resolutions.
// Input stream (s_*): one transaction is a record (tuser 0) or a read (tuser 1).
// A record adds its size and one count to the type's live sums and may roll
// the live sums into level 0's ring and higher levels into the next ring.
// A read returns one level's ring sums for one type plus the largest size.
// Output stream (m_*): exactly one result transaction per input transaction.
// A read sums its ring one slot a cycle. A rollup copies each type's live sums
// into level 0's ring, then checks each higher level it reaches and, for each
// one that rolls, sums the level below's ring per type into it.
// One item is in work at a time.
// Base interval register at APB byte address 0 (16 bits, reset 10).
// Reset clears all sums, stamps and slots; the ring memory is then swept
// clean over all 2^(level bits + type bits + slot bits) entries (2048 at the
// default sizes) while s_tready stays low.
// A stalled output holds its result; a new input transaction is still taken
// and worked on, and its result waits until the held one is taken.
module multilevel_message_traffic_stats_top #(
	parameter int NUM_TYPES     = mmts_pkg::DEF_NUM_TYPES,
	parameter int NUM_LEVELS    = mmts_pkg::DEF_NUM_LEVELS,
	parameter int NUM_DIVISIONS = mmts_pkg::DEF_NUM_DIVISIONS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // msg_type, msg_size, now_seconds, read_level
	input  logic [0:0]  s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,  // total_count, total_size, max_size
	output logic [1:0]  m_tuser,  // status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	mmts_pkg::cmd_t cmd;
	mmts_pkg::sts_t sts;

	// sequencer
	mmts_ctrl #(
		.NUM_TYPES(NUM_TYPES),
		.NUM_LEVELS(NUM_LEVELS),
		.NUM_DIVISIONS(NUM_DIVISIONS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	// stores, sums and result register
	mmts_dp #(
		.NUM_TYPES(NUM_TYPES),
		.NUM_LEVELS(NUM_LEVELS),
		.NUM_DIVISIONS(NUM_DIVISIONS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

endmodule

// ===== tb/sv/multilevel_message_traffic_stats_top_test.sv =====
module multilevel_message_traffic_stats_top_test;

	localparam int NT = mmts_pkg::DEF_NUM_TYPES;
	localparam int NL = mmts_pkg::DEF_NUM_LEVELS;
	localparam int ND = mmts_pkg::DEF_NUM_DIVISIONS;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic        action;
		logic [6:0]  msg_type;
		logic [30:0] msg_size;
		logic [31:0] now_seconds;
		logic [2:0]  read_level;
	} stat_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] total_count;
		logic [31:0] total_size;
		logic [30:0] max_size;
	} stat_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	multilevel_message_traffic_stats_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// model state
	logic [15:0] interval_q;
	logic [31:0] live_sz   [NT];
	logic [31:0] live_cnt  [NT];
	logic [30:0] peak_sz   [NT];
	logic [31:0] ring_sz   [NL][NT][ND];
	logic [31:0] ring_cnt  [NL][NT][ND];
	logic [31:0] lvl_stamp [NL];
	int          lvl_slot  [NL];

	stat_req_t req_queue[$];
	stat_rsp_t rsp_expected[$];
	int        fail_count;
	int        idle_cycles;
	int        send_wait;
	int        recv_wait;
	logic      in_taken;
	logic      out_taken;

	function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	task automatic sum_ring(input int lv, input int t, output logic [31:0] c,
			output logic [31:0] s);
		c = 0;
		s = 0;
		for (int d = 0; d < ND; d++) begin
			c = sat_sum(c, ring_cnt[lv][t][d]);
			s = sat_sum(s, ring_sz[lv][t][d]);
		end
	endtask

	task automatic roll_levels(input logic [31:0] now);
		logic [63:0] span;
		logic [31:0] c, s;
		if ({32'd0, lvl_stamp[0]} + {48'd0, interval_q} >= {32'd0, now})
			return;
		for (int t = 0; t < NT; t++) begin
			ring_sz[0][t][lvl_slot[0]] = live_sz[t];
			ring_cnt[0][t][lvl_slot[0]] = live_cnt[t];
			live_sz[t] = 0;
			live_cnt[t] = 0;
		end
		lvl_stamp[0] = now;
		lvl_slot[0] = (lvl_slot[0] + 1) % ND;
		span = {48'd0, interval_q};
		for (int lv = 1; lv < NL; lv++) begin
			span = span * ND;
			if ({32'd0, lvl_stamp[lv]} + span > {32'd0, now})
				break;
			for (int t = 0; t < NT; t++) begin
				sum_ring(lv - 1, t, c, s);
				ring_cnt[lv][t][lvl_slot[lv]] = c;
				ring_sz[lv][t][lvl_slot[lv]] = s;
			end
			lvl_stamp[lv] = now;
			lvl_slot[lv] = (lvl_slot[lv] + 1) % ND;
		end
	endtask

	task automatic predict_stats(input stat_req_t r);
		stat_rsp_t o;
		logic [31:0] c, s;
		o = '0;
		if (r.msg_type >= NT) begin
			o.status = mmts_pkg::STS_BAD_TYPE;
		end else if (r.action == mmts_pkg::ACT_RECORD) begin
			live_sz[r.msg_type] = sat_sum(live_sz[r.msg_type], {1'b0, r.msg_size});
			live_cnt[r.msg_type] = sat_sum(live_cnt[r.msg_type], 32'd1);
			if (peak_sz[r.msg_type] < r.msg_size)
				peak_sz[r.msg_type] = r.msg_size;
			roll_levels(r.now_seconds);
			o.status = mmts_pkg::STS_OK;
			o.max_size = peak_sz[r.msg_type];
		end else if (r.read_level >= NL) begin
			o.status = mmts_pkg::STS_BAD_LEVEL;
		end else begin
			sum_ring(r.read_level, r.msg_type, c, s);
			o.status = mmts_pkg::STS_OK;
			o.total_count = c;
			o.total_size = s;
			o.max_size = peak_sz[r.msg_type];
		end
		rsp_expected.push_back(o);
	endtask

	function automatic stat_req_t make_req(logic act, int t, logic [30:0] sz,
			logic [31:0] now, int lv);
		stat_req_t r;
		r.action = act;
		r.msg_type = 7'(t);
		r.msg_size = sz;
		r.now_seconds = now;
		r.read_level = 3'(lv);
		return r;
	endfunction

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// input driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				s_tvalid <= 1'b0;
				send_wait <= $urandom_range(0, 4);
			end else if (!s_tvalid) begin
				if (send_wait > 0) begin
					send_wait <= send_wait - 1;
				end else if (req_queue.size() > 0) begin
					stat_req_t r;
					r = req_queue.pop_front();
					predict_stats(r);
					s_tdata <= {8'd0, r.read_level, r.now_seconds, r.msg_size, r.msg_type};
					s_tuser <= r.action;
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// output stall control
	always @(negedge clk) begin
		if (out_taken) begin
			recv_wait = $urandom_range(0, 4);
			if ($urandom_range(0, 3) == 0)
				recv_wait = 0;
		end
		if (recv_wait > 0) begin
			m_tready <= 1'b0;
			recv_wait--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= s_tvalid && s_tready;
			out_taken <= m_tvalid && m_tready;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (m_tvalid && m_tready) begin
				if (rsp_expected.size() == 0) begin
					$error("unexpected transaction status=%0d", m_tuser);
					fail_count++;
				end else begin
					stat_rsp_t e;
					e = rsp_expected.pop_front();
					if (m_tuser !== e.status) begin
						$error("status exp %0d got %0d", e.status, m_tuser);
						fail_count++;
					end
					if (m_tdata[31:0] !== e.total_count) begin
						$error("total_count exp %0d got %0d", e.total_count, m_tdata[31:0]);
						fail_count++;
					end
					if (m_tdata[63:32] !== e.total_size) begin
						$error("total_size exp %0d got %0d", e.total_size, m_tdata[63:32]);
						fail_count++;
					end
					if (m_tdata[94:64] !== e.max_size) begin
						$error("max_size exp %0d got %0d", e.max_size, m_tdata[94:64]);
						fail_count++;
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("multilevel_message_traffic_stats_top test failed");
				$finish;
			end
		end
	end

	task automatic write_interval(input logic [15:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(mmts_pkg::REG_BASE_INTERVAL * 4);
		pwdata <= {16'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		interval_q = v;
	endtask

	task automatic drain_all();
		while (req_queue.size() > 0 || s_tvalid || rsp_expected.size() > 0)
			@(posedge clk);
		// then wait for as long as a full rollup could take
		repeat ((ND + 2) * NT * NL + 4 * NT) @(posedge clk);
	endtask

	// random phase: mostly records with time moving forward, some reads
	task automatic random_phase(input int n, inout logic [31:0] clock_s);
		int t, lv;
		logic [30:0] sz;
		for (int i = 0; i < n; i++) begin
			t = ($urandom_range(0, 15) == 0) ? $urandom_range(NT, 127) : $urandom_range(0, 7);
			if ($urandom_range(0, 9) == 0) t = $urandom_range(0, NT - 1);
			case ($urandom_range(0, 3))
				0: sz = 31'($urandom);
				1: sz = 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
				default: sz = 31'($urandom_range(0, 2000));
			endcase
			if ($urandom_range(0, 19) == 0)
				clock_s = clock_s - $urandom_range(0, 50);
			else if ($urandom_range(0, 49) == 0)
				clock_s = $urandom;
			else
				clock_s = clock_s + $urandom_range(0, 2 * interval_q + 2);
			lv = ($urandom_range(0, 7) == 0) ? $urandom_range(NL, 7) : $urandom_range(0, NL - 1);
			if ($urandom_range(0, 3) == 0)
				req_queue.push_back(make_req(mmts_pkg::ACT_READ, t, sz, $urandom, lv));
			else
				req_queue.push_back(make_req(mmts_pkg::ACT_RECORD, t, sz, clock_s,
					$urandom_range(0, 7)));
		end
	endtask

	initial begin
		logic [31:0] clock_s;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		idle_cycles = 0;
		send_wait = 0;
		recv_wait = 0;
		in_taken = 1'b0;
		out_taken = 1'b0;
		interval_q = mmts_pkg::BASE_RESET;
		for (int t = 0; t < NT; t++) begin
			live_sz[t] = 0;
			live_cnt[t] = 0;
			peak_sz[t] = 0;
			for (int l = 0; l < NL; l++)
				for (int d = 0; d < ND; d++) begin
					ring_sz[l][t][d] = 0;
					ring_cnt[l][t][d] = 0;
				end
		end
		for (int l = 0; l < NL; l++) begin
			lvl_stamp[l] = 0;
			lvl_slot[l] = 0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset interval, extremes, bad type and level, saturation
		req_queue.push_back(make_req(mmts_pkg::ACT_READ, 0, 0, 0, 0));
		req_queue.push_back(make_req(mmts_pkg::ACT_RECORD, 0, 31'h7FFF_FFFF, 0, 0));
		req_queue.push_back(make_req(mmts_pkg::ACT_RECORD, 0, 31'h7FFF_FFFF, 10, 7));
		req_queue.push_back(make_req(mmts_pkg::ACT_RECORD, 0, 31'h7FFF_FFFF, 5, 0));
		req_queue.push_back(make_req(mmts_pkg::ACT_RECORD, NT - 1, 0, 11, 0));
		req_queue.push_back(make_req(mmts_pkg::ACT_READ, 0, 0, 0, 0));
		req_queue.push_back(make_req(mmts_pkg::ACT_READ, NT - 1, 31'h7FFF_FFFF,
			32'hFFFF_FFFF, NL - 1));
		req_queue.push_back(make_req(mmts_pkg::ACT_READ, 1, 0, 0, NL));
		req_queue.push_back(make_req(mmts_pkg::ACT_READ, 1, 0, 0, 7));
		req_queue.push_back(make_req(mmts_pkg::ACT_RECORD, NT, 5, 100, 0));
		req_queue.push_back(make_req(mmts_pkg::ACT_READ, 127, 5, 100, 7));
		req_queue.push_back(make_req(mmts_pkg::ACT_RECORD, 3, 31'h5555_5555, 32'hFFFF_FFF0, 5));
		req_queue.push_back(make_req(mmts_pkg::ACT_RECORD, 3, 31'h2AAA_AAAA, 32'hFFFF_FFFF, 2));
		req_queue.push_back(make_req(mmts_pkg::ACT_RECORD, 3, 1, 20, 0));
		for (int l = 0; l < NL; l++)
			req_queue.push_back(make_req(mmts_pkg::ACT_READ, 0, 0, 0, l));
		drain_all();

		// zero interval: a record rolls whenever its time is past the level 0 stamp
		write_interval(16'd0);
		for (int i = 0; i < 6; i++)
			req_queue.push_back(make_req(mmts_pkg::ACT_RECORD, 2, 31'h7FFF_FFFF, i, 0));
		for (int l = 0; l < NL; l++)
			req_queue.push_back(make_req(mmts_pkg::ACT_READ, 2, 0, 0, l));
		drain_all();

		clock_s = 100;
		write_interval(16'd1);
		random_phase(500, clock_s);
		drain_all();
		write_interval(16'd3);
		random_phase(500, clock_s);
		drain_all();
		write_interval(16'hFFFF);
		clock_s = 32'h8000_0000;
		random_phase(200, clock_s);
		drain_all();
		write_interval(16'd2);
		random_phase(300, clock_s);
		drain_all();

		if (fail_count == 0)
			$display("multilevel_message_traffic_stats_top test passed");
		else
			$display("multilevel_message_traffic_stats_top test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/mmts_pkg.sv
src/mmts_ctrl.sv
src/mmts_dp.sv
src/multilevel_message_traffic_stats_top.sv
tb/sv/multilevel_message_traffic_stats_top_test.sv
